>>> src/mssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, codes, segment constants and the digit table for the
// multiplexed seven-segment display unit.
// ----------------------------------------------------------------------------
package mssd_pkg;

	// command codes carried in the func field
	typedef enum logic [2:0] {
		FUNC_TICK  = 3'd0,
		FUNC_INT   = 3'd1,
		FUNC_FREQ  = 3'd2,
		FUNC_VOL   = 3'd3,
		FUNC_BLANK = 3'd4
	} func_t;

	// one input item
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] value;
		logic        asleep;
	} req_item_t;

	// one result item
	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] digit_enable;
	} rsp_item_t;

	// four digit patterns, index 0 units .. 3 thousands
	typedef logic [3:0][7:0] digit_set_t;

	// pattern update from the decoder to the scan logic
	typedef struct packed {
		logic       we;
		digit_set_t pattern;
	} pat_upd_t;

	localparam int unsigned SCAN_PERIOD_DEF = 5;
	localparam logic [7:0]  THRESHOLD_RST   = 8'd1;

	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [7:0] SEG_V     = 8'hC1;
	localparam logic [7:0] DP_MASK   = 8'h7F;

	// reciprocals for exact division of a 16-bit value: q = (v * m) >> k
	localparam logic [16:0] RECIP_10    = 17'd104858;
	localparam int unsigned SHIFT_10    = 20;
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int unsigned SHIFT_100   = 23;
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam int unsigned SHIFT_1000  = 26;
	localparam logic [16:0] RECIP_10000 = 17'd107375;
	localparam int unsigned SHIFT_10000 = 30;

	// reciprocals for an 8-bit value
	localparam logic [15:0] RECIP8_10  = 16'd205;
	localparam int unsigned SHIFT8_10  = 11;
	localparam logic [15:0] RECIP8_100 = 16'd41;
	localparam int unsigned SHIFT8_100 = 12;

	// active-low segment pattern of a decimal digit
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0:    seg = 8'hC0;
			4'd1:    seg = 8'hF9;
			4'd2:    seg = 8'hA4;
			4'd3:    seg = 8'hB0;
			4'd4:    seg = 8'h99;
			4'd5:    seg = 8'h92;
			4'd6:    seg = 8'h82;
			4'd7:    seg = 8'hF8;
			4'd8:    seg = 8'h80;
			4'd9:    seg = 8'h90;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage
`default_nettype wire

>>> src/mssd_pattern.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssd_pattern
// Decimal split and digit pattern generation for the display commands.
// ----------------------------------------------------------------------------
module mssd_pattern (
	input  mssd_pkg::req_item_t item,
	output mssd_pkg::pat_upd_t  upd
);
	import mssd_pkg::*;

	logic [32:0] prod_10, prod_100, prod_1000, prod_10000;
	logic [15:0] q1, q2, q3, q4;
	logic [3:0]  d0, d1, d2, d3;
	logic [7:0]  vol, v10, v100;
	logic [15:0] vprod_10, vprod_100;

	// low decimal digit of q, given q / 10
	function automatic logic [3:0] low_digit(input logic [15:0] q, input logic [15:0] q_div10);
		logic [15:0] tens;
		tens = 16'(q_div10 << 3) + 16'(q_div10 << 1);
		return 4'(q - tens);
	endfunction

	// parallel quotients by 10, 100, 1000 and 10000
	always_comb begin
		prod_10    = 33'(item.value) * 33'(RECIP_10);
		prod_100   = 33'(item.value) * 33'(RECIP_100);
		prod_1000  = 33'(item.value) * 33'(RECIP_1000);
		prod_10000 = 33'(item.value) * 33'(RECIP_10000);
		q1 = 16'(prod_10 >> SHIFT_10);
		q2 = 16'(prod_100 >> SHIFT_100);
		q3 = 16'(prod_1000 >> SHIFT_1000);
		q4 = 16'(prod_10000 >> SHIFT_10000);
		d0 = low_digit(item.value, q1);
		d1 = low_digit(q1, q2);
		d2 = low_digit(q2, q3);
		d3 = low_digit(q3, q4);
	end

	// volume split on the low byte
	always_comb begin
		vol       = item.value[7:0];
		vprod_10  = 16'(vol) * RECIP8_10;
		vprod_100 = 16'(vol) * RECIP8_100;
		v10       = 8'(vprod_10 >> SHIFT8_10);
		v100      = 8'(vprod_100 >> SHIFT8_100);
	end

	// pattern selection per command
	always_comb begin
		upd.we      = 1'b0;
		upd.pattern = {4{SEG_BLANK}};
		case (item.func)
			FUNC_INT: begin
				upd.we      = 1'b1;
				upd.pattern = {seg_of(d3), seg_of(d2), seg_of(d1), seg_of(d0)};
			end
			FUNC_FREQ: begin
				upd.we         = 1'b1;
				upd.pattern[0] = seg_of(d1);
				upd.pattern[1] = seg_of(d2) & DP_MASK;
				upd.pattern[2] = seg_of(d3);
				upd.pattern[3] = (q4 == 16'd0) ? SEG_BLANK : seg_of(4'(q4));
			end
			FUNC_VOL: begin
				upd.we         = 1'b1;
				upd.pattern[0] = seg_of(4'(vol - (8'({v10, 3'b000}) + 8'({v10, 1'b0}))));
				upd.pattern[1] = seg_of(4'(v10 - (8'({v100, 3'b000}) + 8'({v100, 1'b0}))));
				upd.pattern[2] = (v100 == 8'd0) ? SEG_BLANK : seg_of(4'(v100));
				upd.pattern[3] = SEG_V;
			end
			FUNC_BLANK: begin
				upd.we      = 1'b1;
				upd.pattern = {4{SEG_BLANK}};
			end
			default: begin
				upd.we      = 1'b0;
				upd.pattern = {4{SEG_BLANK}};
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/mssd_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mssd_scan
// Digit pattern store, brightness dimmer, round-robin digit scan and the
// result register.
// ----------------------------------------------------------------------------
module mssd_scan #(
	parameter int unsigned SCAN_PERIOD = mssd_pkg::SCAN_PERIOD_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_s1,
	input  mssd_pkg::req_item_t  item_s1,
	input  mssd_pkg::pat_upd_t   upd,
	output logic                 advance,
	input  wire                  cfg_we,
	input  wire [7:0]            cfg_data,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output mssd_pkg::rsp_item_t  rsp_item
);
	import mssd_pkg::*;

	localparam logic [7:0] PERIOD_LIMIT = 8'(SCAN_PERIOD);

	digit_set_t pattern_q;
	logic [1:0] scan_q;
	logic [7:0] period_q;
	logic [7:0] last_q;
	logic [7:0] thr_q;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;

	logic       is_tick;
	logic       out_free;
	logic       fire;
	logic       drive;
	logic [7:0] period_inc;

	// handshake and tick decision
	always_comb begin
		is_tick    = valid_s1 && (item_s1.func == FUNC_TICK);
		out_free   = !rsp_valid_q || !rsp_stall;
		advance    = !is_tick || out_free;
		fire       = is_tick && out_free;
		period_inc = period_q + 8'd1;
		drive      = !item_s1.asleep && (period_inc >= thr_q);
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// digit pattern store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
		end else if (valid_s1 && upd.we) begin
			pattern_q <= upd.pattern;
		end
	end

	// dimmer counter, scan position and last driven byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			period_q <= '0;
			last_q   <= '0;
		end else if (fire && !item_s1.asleep) begin
			if (drive) begin
				last_q   <= pattern_q[scan_q];
				scan_q   <= scan_q + 2'd1;
				period_q <= (period_inc >= PERIOD_LIMIT) ? 8'd0 : period_inc;
			end else begin
				period_q <= period_inc;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= fire || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.segments     <= drive ? pattern_q[scan_q] : last_q;
			rsp_q.digit_enable <= drive ? 4'(4'b0001 << scan_q) : 4'b0000;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	// checks
	a_enable_onehot : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> $onehot0(rsp_q.digit_enable))
		else $error("digit enable not one-hot");

	a_segments_last : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.segments == last_q))
		else $error("result segments differ from last driven byte");

	a_scan_step : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && drive) |=> (scan_q == 2'($past(scan_q) + 2'd1)))
		else $error("scan position did not step after a driven tick");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && !out_free) |=> ($stable(period_q) && $stable(scan_q)))
		else $error("dimmer state moved on a stalled tick");

endmodule
`default_nettype wire

>>> src/muxed_seven_segment_display_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// muxed_seven_segment_display_unit
// Four-digit multiplexed common-anode seven-segment driver with dimmer.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while input stall is low. Each item
// enters an input register; from there the decimal split (four parallel
// constant-reciprocal multiplies) and the scan logic settle it, and a tick's
// result lands in the output register once that register is free to take it.
// Display commands update the four digit patterns and give no result; ticks
// give exactly one. Input stall rises only when a tick waits in the input
// register while the output register holds an untaken result.
module muxed_seven_segment_display_unit #(
	parameter int unsigned SCAN_PERIOD = mssd_pkg::SCAN_PERIOD_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  mssd_pkg::req_item_t  req_item,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output mssd_pkg::rsp_item_t  rsp_item,
	input  wire                  cfg_we,
	input  wire [7:0]            cfg_data
);
	import mssd_pkg::*;

	logic      valid_s1;
	req_item_t item_s1;
	pat_upd_t  upd;
	logic      advance;

	assign req_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_item;
		end
	end

	// digit pattern generation
	mssd_pattern u_pattern (
		.item (item_s1),
		.upd  (upd)
	);

	// scan, dimmer and result register
	mssd_scan #(
		.SCAN_PERIOD (SCAN_PERIOD)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.upd       (upd),
		.advance   (advance),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule
`default_nettype wire
